### src/soaf_pkg.sv
`default_nettype none

package soaf_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned FLAGS_W = 4;
	localparam int unsigned REG_W   = 4;

	localparam logic [REG_W-1:0] PC_INDEX  = 4'hF;
	localparam logic [7:0]       AMT_MASK  = 8'hFF;
	localparam logic [4:0]       IMM_AMT_W = 5'h1F;
	localparam logic [1:0]       TEST_GRP  = 2'b10;
	localparam logic [WORD_W-1:0] PC_AHEAD = 32'd4;

	typedef enum logic [3:0] {
		OP_AND = 4'd0,
		OP_EOR = 4'd1,
		OP_SUB = 4'd2,
		OP_RSB = 4'd3,
		OP_ADD = 4'd4,
		OP_ADC = 4'd5,
		OP_SBC = 4'd6,
		OP_RSC = 4'd7,
		OP_TST = 4'd8,
		OP_TEQ = 4'd9,
		OP_CMP = 4'd10,
		OP_CMN = 4'd11,
		OP_ORR = 4'd12,
		OP_MOV = 4'd13,
		OP_BIC = 4'd14,
		OP_MVN = 4'd15
	} soaf_op_t;

	typedef enum logic [1:0] {
		SH_LSL = 2'd0,
		SH_LSR = 2'd1,
		SH_ASR = 2'd2,
		SH_ROR = 2'd3
	} soaf_shift_t;

	typedef struct packed {
		logic [WORD_W-1:0]  instruction;
		logic [WORD_W-1:0]  first_value;
		logic [WORD_W-1:0]  second_value;
		logic [WORD_W-1:0]  shift_value;
		logic [FLAGS_W-1:0] flags_in;
	} soaf_cmd_t;

	typedef struct packed {
		logic [WORD_W-1:0]  result;
		logic [REG_W-1:0]   dest_index;
		logic               write_dest;
		logic [FLAGS_W-1:0] flags_out;
		logic               restore_status;
		logic               psr_transfer;
	} soaf_res_t;

endpackage

`default_nettype wire

### src/soaf_operand.sv
`default_nettype none

module soaf_operand import soaf_pkg::*; (
	input  wire logic [WORD_W-1:0] instruction,
	input  wire logic [WORD_W-1:0] second_value,
	input  wire logic [7:0]        shift_amount,
	input  wire logic              carry_in,
	output logic      [WORD_W-1:0] operand,
	output logic                   carry_out
);

	logic [7:0]        imm;
	logic [4:0]        rot;
	logic [63:0]       imm_w;
	logic              by_reg;
	soaf_shift_t       typ;
	logic [WORD_W-1:0] v;
	logic [7:0]        amt;
	logic              imm_zero;
	logic [7:0]        eff;
	logic [32:0]       lsl_w;
	logic [32:0]       lsr_w;
	logic signed [32:0] asr_in;
	logic signed [32:0] asr_w;
	logic [5:0]        asr_n;
	logic [63:0]       ror_w;

	assign imm    = instruction[7:0];
	assign rot    = {instruction[11:8], 1'b0};
	assign imm_w  = {24'd0, imm, 24'd0, imm} >> rot;
	assign by_reg = instruction[4];
	assign typ    = soaf_shift_t'(instruction[6:5]);
	assign v      = (by_reg && (instruction[3:0] == PC_INDEX)) ? second_value + PC_AHEAD
		: second_value;
	assign amt      = by_reg ? (shift_amount & AMT_MASK) : {3'd0, instruction[11:7] & IMM_AMT_W};
	assign imm_zero = !by_reg && (amt == 8'd0);
	assign eff      = imm_zero ? 8'd32 : amt;
	assign lsl_w  = {1'b0, v} << eff[5:0];
	assign lsr_w  = {v, 1'b0} >> eff[5:0];
	assign asr_in = {v, 1'b0};
	assign asr_n  = (eff >= 8'd32) ? 6'd32 : eff[5:0];
	assign asr_w  = asr_in >>> asr_n;
	assign ror_w  = {v, v} >> eff[4:0];

	always_comb begin
		operand   = v;
		carry_out = carry_in;
		if (instruction[25]) begin
			operand = imm_w[31:0];
			if (rot != 5'd0) begin
				carry_out = imm_w[31];
			end
		end else if (imm_zero && (typ == SH_LSL)) begin
			operand = v;
		end else if (imm_zero && (typ == SH_ROR)) begin
			operand   = {carry_in, v[31:1]};
			carry_out = v[0];
		end else if (by_reg && (amt == 8'd0)) begin
			operand = v;
		end else begin
			case (typ)
				SH_LSL: begin
					if (eff <= 8'd32) begin
						operand   = lsl_w[31:0];
						carry_out = lsl_w[32];
					end else begin
						operand   = '0;
						carry_out = 1'b0;
					end
				end
				SH_LSR: begin
					if (eff <= 8'd32) begin
						operand   = lsr_w[32:1];
						carry_out = lsr_w[0];
					end else begin
						operand   = '0;
						carry_out = 1'b0;
					end
				end
				SH_ASR: begin
					operand   = asr_w[32:1];
					carry_out = asr_w[0];
				end
				default: begin
					operand   = ror_w[31:0];
					carry_out = ror_w[31];
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### src/shifted_operand_alu_flags.sv
// A word accepted at a clock edge goes through the input register and the result register to res with done.
// Throughput: one word per cycle; busy is held low, start may be high in every cycle.
// Timing is set by the operand shifter feeding the 33-bit adder between the two registers.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset (arst_n low, asynchronous) clears the pipeline valid bits only.
`default_nettype none

module shifted_operand_alu_flags import soaf_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire soaf_cmd_t cmd,
	output logic           done,
	output soaf_res_t      res
);

	logic      valid_s1;
	soaf_cmd_t cmd_s1;
	logic      done_s2;
	soaf_res_t res_s2;

	soaf_op_t          op;
	logic              s_bit;
	logic [REG_W-1:0]  rn;
	logic [REG_W-1:0]  rd;
	logic              test;
	logic              psr;
	logic              restore;
	logic              s_eff;
	logic              cold;
	logic              sc;
	logic [WORD_W-1:0] a;
	logic [WORD_W-1:0] b;
	logic [WORD_W-1:0] add_x;
	logic [WORD_W-1:0] add_y;
	logic              add_ci;
	logic [32:0]       sum;
	logic              add_v;
	logic              logical;
	logic [WORD_W-1:0] r;
	logic [FLAGS_W-1:0] fnew;
	soaf_res_t         res_d;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done_s2  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
		if (valid_s1) begin
			res_s2 <= res_d;
		end
	end

	assign op      = soaf_op_t'(cmd_s1.instruction[24:21]);
	assign s_bit   = cmd_s1.instruction[20];
	assign rn      = cmd_s1.instruction[19:16];
	assign rd      = cmd_s1.instruction[15:12];
	assign test    = (cmd_s1.instruction[24:23] == TEST_GRP);
	assign psr     = !s_bit && test;
	assign restore = s_bit && (rd == PC_INDEX);
	assign s_eff   = s_bit && !restore;
	assign cold    = cmd_s1.flags_in[1];

	assign a = (!cmd_s1.instruction[25] && cmd_s1.instruction[4] && (rn == PC_INDEX))
		? cmd_s1.first_value + PC_AHEAD : cmd_s1.first_value;

	soaf_operand u_operand (
		.instruction  (cmd_s1.instruction),
		.second_value (cmd_s1.second_value),
		.shift_amount (cmd_s1.shift_value[7:0]),
		.carry_in     (cold),
		.operand      (b),
		.carry_out    (sc)
	);

	always_comb begin
		add_x = a;
		add_y = b;
		add_ci = 1'b0;
		case (op) inside
			OP_SUB, OP_CMP: begin
				add_y  = ~b;
				add_ci = 1'b1;
			end
			OP_RSB: begin
				add_x  = b;
				add_y  = ~a;
				add_ci = 1'b1;
			end
			OP_ADC: begin
				add_ci = cold;
			end
			OP_SBC: begin
				add_y  = ~b;
				add_ci = cold;
			end
			OP_RSC: begin
				add_x  = b;
				add_y  = ~a;
				add_ci = cold;
			end
			default: begin
				add_ci = 1'b0;
			end
		endcase
	end

	assign sum   = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_ci};
	assign add_v = ~(add_x[31] ^ add_y[31]) & (add_x[31] ^ sum[31]);

	always_comb begin
		logical = 1'b1;
		r       = sum[31:0];
		case (op) inside
			OP_AND, OP_TST: r = a & b;
			OP_EOR, OP_TEQ: r = a ^ b;
			OP_ORR:         r = a | b;
			OP_MOV:         r = b;
			OP_BIC:         r = a & ~b;
			OP_MVN:         r = ~b;
			default: begin
				logical = 1'b0;
				r       = sum[31:0];
			end
		endcase
	end

	always_comb begin
		fnew = cmd_s1.flags_in;
		if (s_eff || test) begin
			if (logical) begin
				fnew = {r[31], (r == '0), sc, cmd_s1.flags_in[0]};
			end else begin
				fnew = {r[31], (r == '0), sum[32], add_v};
			end
		end
	end

	always_comb begin
		if (psr) begin
			res_d.result         = '0;
			res_d.dest_index     = '0;
			res_d.write_dest     = 1'b0;
			res_d.flags_out      = cmd_s1.flags_in;
			res_d.restore_status = 1'b0;
			res_d.psr_transfer   = 1'b1;
		end else begin
			res_d.result         = r;
			res_d.dest_index     = rd;
			res_d.write_dest     = !test;
			res_d.flags_out      = fnew;
			res_d.restore_status = restore;
			res_d.psr_transfer   = 1'b0;
		end
	end

	assign done = done_s2;
	assign res  = res_s2;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("accepted word did not reach the result register");

	a_psr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.psr_transfer |-> !res.write_dest && !res.restore_status)
		else $error("status transfer produced a write or a restore");

	a_restore_pc: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.restore_status |-> res.dest_index == PC_INDEX)
		else $error("restore requested for a destination other than the PC");

endmodule

`default_nettype wire

### sim/soaf_checker.sv
`default_nettype none

module soaf_checker import soaf_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire logic      busy,
	input  wire soaf_cmd_t cmd,
	input  wire logic      done,
	input  wire soaf_res_t res,
	output int             errors,
	output int             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	soaf_res_t dp_results_due[$];

	// Returns {carry, value} of operand two after the shifter.
	function automatic logic [32:0] barrel(logic [31:0] v, soaf_shift_t kind,
			logic [7:0] amt, bit by_reg, bit cin);
		int n;
		logic signed [31:0] sv;
		logic [31:0] rr;
		n = int'(amt);
		sv = v;
		if (amt == 8'd0) begin
			if (by_reg || kind == SH_LSL)
				return {cin, v};
			if (kind == SH_ROR)
				return {v[0], cin, v[31:1]};
			n = 32;
		end
		case (kind)
		SH_LSL: begin
			if (n < 32)
				return {v[32 - n], v << n};
			return {(n == 32) && v[0], 32'h0};
		end
		SH_LSR: begin
			if (n < 32)
				return {v[n - 1], v >> n};
			return {(n == 32) && v[31], 32'h0};
		end
		SH_ASR: begin
			if (n < 32) begin
				rr = sv >>> n;
				return {v[n - 1], rr};
			end
			return {v[31], {32{v[31]}}};
		end
		default: begin
			n = n & 31;
			if (n == 0)
				return {v[31], v};
			rr = (v >> n) | (v << (32 - n));
			return {rr[31], rr};
		end
		endcase
	endfunction

	// Returns {NZCV, sum}. Subtraction is done as x + ~y + carry.
	function automatic logic [35:0] add_nzcv(logic [31:0] x, logic [31:0] y, bit cin);
		logic [32:0] s;
		logic [31:0] r;
		logic [31:0] ovf;
		s = {1'b0, x} + {1'b0, y} + {32'h0, cin};
		r = s[31:0];
		ovf = ~(x ^ y) & (x ^ r);
		return {r[31], r == 32'h0, s[32], ovf[31], r};
	endfunction

	function automatic soaf_res_t exec_dp_word(soaf_cmd_t c);
		soaf_res_t o;
		logic [31:0] ins;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] r;
		logic [35:0] sum;
		logic [32:0] sh;
		logic [7:0] amt;
		logic [3:0] rn;
		logic [3:0] rd;
		logic [3:0] arith_flags;
		int rot;
		soaf_op_t op;
		bit s;
		bit test;
		bit restore;
		bit logical;
		bit sc;
		bit cold;
		ins = c.instruction;
		a = c.first_value;
		op = soaf_op_t'(ins[24:21]);
		s = ins[20];
		rn = ins[19:16];
		rd = ins[15:12];
		cold = c.flags_in[1];
		sc = cold;
		test = (ins[24:23] == TEST_GRP);
		o = '0;
		o.flags_out = c.flags_in;
		if (!s && test) begin
			o.psr_transfer = 1'b1;
			return o;
		end
		restore = s && (rd == PC_INDEX);
		if (restore)
			s = 1'b0;
		if (ins[25]) begin
			rot = int'(ins[11:8]) * 2;
			b = {24'h0, ins[7:0]};
			if (rot != 0) begin
				b = (b >> rot) | (b << (32 - rot));
				sc = b[31];
			end
		end else begin
			b = c.second_value;
			if (ins[4]) begin
				if (ins[3:0] == PC_INDEX)
					b = b + PC_AHEAD;
				if (rn == PC_INDEX)
					a = a + PC_AHEAD;
				amt = c.shift_value[7:0] & AMT_MASK;
			end else begin
				amt = {3'b000, ins[11:7] & IMM_AMT_W};
			end
			sh = barrel(b, soaf_shift_t'(ins[6:5]), amt, ins[4], sc);
			sc = sh[32];
			b = sh[31:0];
		end
		logical = 1'b0;
		sum = '0;
		case (op)
		OP_AND, OP_TST: begin r = a & b; logical = 1'b1; end
		OP_EOR, OP_TEQ: begin r = a ^ b; logical = 1'b1; end
		OP_SUB, OP_CMP: sum = add_nzcv(a, ~b, 1'b1);
		OP_RSB: sum = add_nzcv(b, ~a, 1'b1);
		OP_ADD, OP_CMN: sum = add_nzcv(a, b, 1'b0);
		OP_ADC: sum = add_nzcv(a, b, cold);
		OP_SBC: sum = add_nzcv(a, ~b, cold);
		OP_RSC: sum = add_nzcv(b, ~a, cold);
		OP_ORR: begin r = a | b; logical = 1'b1; end
		OP_MOV: begin r = b; logical = 1'b1; end
		OP_BIC: begin r = a & ~b; logical = 1'b1; end
		default: begin r = ~b; logical = 1'b1; end
		endcase
		if (!logical)
			r = sum[31:0];
		arith_flags = sum[35:32];
		if (s || test)
			o.flags_out = logical ? {r[31], r == 32'h0, sc, c.flags_in[0]} : arith_flags;
		o.result = r;
		o.dest_index = rd;
		o.write_dest = !test;
		o.restore_status = restore;
		return o;
	endfunction

	initial begin
		errors = 0;
		outstanding = 0;
	end

	always @(posedge clk) begin
		soaf_res_t want;
		if (arst_n) begin
			if (done) begin
				if (dp_results_due.size() == 0) begin
					if (errors < 10)
						$display("%0t: result word with nothing pending: result %h rd %h",
							$time, res.result, res.dest_index);
					errors++;
				end else begin
					want = dp_results_due.pop_front();
					if (res.result !== want.result || res.dest_index !== want.dest_index ||
							res.write_dest !== want.write_dest ||
							res.flags_out !== want.flags_out ||
							res.restore_status !== want.restore_status ||
							res.psr_transfer !== want.psr_transfer) begin
						if (errors < 10) begin
							$display("%0t: mismatch", $time);
							$display("  wanted result %h rd %h we %b nzcv %b rst %b psr %b",
								want.result, want.dest_index, want.write_dest,
								want.flags_out, want.restore_status, want.psr_transfer);
							$display("  got    result %h rd %h we %b nzcv %b rst %b psr %b",
								res.result, res.dest_index, res.write_dest,
								res.flags_out, res.restore_status, res.psr_transfer);
						end
						errors++;
					end
				end
			end
			if (start && !busy)
				dp_results_due.push_back(exec_dp_word(cmd));
		end
		outstanding <= dp_results_due.size();
	end

endmodule

`default_nettype wire

### sim/tb_top.sv
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import soaf_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 100000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        done;
	soaf_cmd_t   cmd;
	soaf_res_t   res;
	int          errors;
	int          outstanding;
	int unsigned cycles = 0;

	shifted_operand_alu_flags uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.res    (res)
	);

	soaf_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.done        (done),
		.res         (res),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	function automatic logic [31:0] dp_word(bit imm, soaf_op_t op, bit s, logic [3:0] rn,
			logic [3:0] rd, logic [11:0] op2);
		return {4'hE, 2'b00, imm, op, s, rn, rd, op2};
	endfunction

	function automatic logic [31:0] pick_operand_value();
		case ($urandom_range(5))
		0: return 32'h0000_0000;
		1: return 32'hFFFF_FFFF;
		2: return 32'h8000_0000;
		3: return 32'h7FFF_FFFF;
		default: return $urandom;
		endcase
	endfunction

	function automatic soaf_cmd_t random_word();
		soaf_cmd_t c;
		logic [31:0] ins;
		logic [31:0] rs;
		ins = $urandom;
		if ($urandom_range(4) == 0)
			ins[11:7] = 5'd0;
		case ($urandom_range(5))
		0: ins[15:12] = PC_INDEX;
		1: ins[19:16] = PC_INDEX;
		2: ins[3:0] = PC_INDEX;
		3: begin
			ins[19:16] = PC_INDEX;
			ins[3:0] = PC_INDEX;
		end
		default: ;
		endcase
		rs = $urandom;
		case ($urandom_range(4))
		0: rs[7:0] = 8'd0;
		1: rs[7:0] = 8'd32;
		2: rs[7:0] = 8'($urandom_range(1, 31));
		3: rs[7:0] = 8'($urandom_range(33, 255));
		default: ;
		endcase
		c.instruction = ins;
		c.first_value = pick_operand_value();
		c.second_value = pick_operand_value();
		c.shift_value = rs;
		c.flags_in = 4'($urandom);
		return c;
	endfunction

	// Holds the word on cmd until the block takes it.
	task automatic send_word(soaf_cmd_t c, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [11:0] op2;
		logic [31:0] rs;
		bit imm;
		int idle;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < 16; k++) begin
			imm = 1'b0;
			rs = 32'h0;
			op2 = '0;
			case (k)
			0: begin imm = 1'b1; op2 = 12'h0FF; end
			1: begin imm = 1'b1; op2 = 12'hFFF; end
			2: op2 = {5'd0, SH_LSL, 1'b0, 4'd2};
			3: op2 = {5'd0, SH_LSR, 1'b0, 4'd2};
			4: op2 = {5'd0, SH_ASR, 1'b0, 4'd2};
			5: op2 = {5'd0, SH_ROR, 1'b0, 4'd2};
			6: op2 = {5'd31, SH_LSL, 1'b0, 4'd2};
			7: begin op2 = {4'd4, 1'b0, SH_LSL, 1'b1, PC_INDEX}; rs = 32'hFFFF_FF00; end
			8: begin op2 = {4'd4, 1'b0, SH_LSL, 1'b1, 4'd2}; rs = 32'd32; end
			9: begin op2 = {4'd4, 1'b0, SH_LSL, 1'b1, 4'd2}; rs = 32'd33; end
			10: begin op2 = {4'd4, 1'b0, SH_LSR, 1'b1, 4'd2}; rs = 32'd32; end
			11: begin op2 = {4'd4, 1'b0, SH_LSR, 1'b1, 4'd2}; rs = 32'd255; end
			12: begin op2 = {4'd4, 1'b0, SH_ASR, 1'b1, 4'd2}; rs = 32'd40; end
			13: begin op2 = {4'd4, 1'b0, SH_ROR, 1'b1, 4'd2}; rs = 32'd32; end
			14: begin op2 = {4'd4, 1'b0, SH_ROR, 1'b1, 4'd2}; rs = 32'd1; end
			default: op2 = {5'd1, SH_ASR, 1'b0, 4'd2};
			endcase
			send_word({dp_word(imm, soaf_op_t'(k), 1'b1, PC_INDEX, 4'd3, op2),
				k[0] ? 32'hFFFF_FFFF : 32'h8000_0001,
				k[1] ? 32'h8000_0000 : 32'h7FFF_FFFF,
				rs, 4'(k) ^ 4'hA}, 0);
		end
		send_word({dp_word(1'b0, OP_TST, 1'b0, 4'd1, 4'd2, 12'h003),
			32'h1234_5678, 32'h9ABC_DEF0, 32'h0, 4'h5}, 0);
		send_word({dp_word(1'b1, OP_MOV, 1'b1, 4'd0, PC_INDEX, 12'h000),
			32'h0, 32'h0, 32'h0, 4'hF}, 0);
		send_word({dp_word(1'b1, OP_CMP, 1'b1, 4'd1, PC_INDEX, 12'h401),
			32'h1000_0000, 32'h0, 32'h0, 4'h0}, 0);
		send_word({32'h0, 32'h0, 32'h0, 32'h0, 4'h0}, 0);
		send_word({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF}, 0);
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			case (p)
			1: idle = 68;
			2: idle = 23;
			default: idle = 0;
			endcase
			for (int i = 0; i < 213; i++)
				send_word(random_word(), idle);
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
src/soaf_pkg.sv
src/soaf_operand.sv
src/shifted_operand_alu_flags.sv
sim/soaf_checker.sv
sim/tb_top.sv
